### hdl/imu_ssgb_pkg.sv
// imu_ssgb_pkg: types and constants for the imu sample scale and gyro bias block
// used by imu_ssgb_div and imu_sample_scale_gyro_bias; no dependencies
`timescale 1ns / 1ps

package imu_ssgb_pkg;

    localparam int DIV_W        = 40;
    localparam int DEN_W        = 16;
    localparam int ITER_W       = 6;
    localparam int NARROW_ITERS = 25;
    localparam int NUM_W        = DIV_W + 1;

    localparam logic [1:0] CMD_MEASURE = 2'd0;
    localparam logic [1:0] CMD_CALIB   = 2'd1;
    localparam logic [1:0] CMD_BEGIN   = 2'd2;

    localparam logic [2:0] OP_BIAS_X = 3'd0;
    localparam logic [2:0] OP_BIAS_Z = 3'd2;
    localparam logic [2:0] OP_RATE_X = 3'd3;
    localparam logic [2:0] OP_TEMP   = 3'd6;

    localparam logic [15:0] CALIB_SAMPLES_RESET = 16'd100;
    localparam logic [15:0] RATE_DEN            = 16'd131;
    localparam logic [15:0] TEMP_DEN            = 16'd17;
    localparam logic [14:0] TEMP_OFFSET         = 15'd3653;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic wide;
    } div_req_t;

endpackage

### hdl/imu_ssgb_div.sv
// imu_ssgb_div: shared restoring divider, one quotient bit per cycle
// 40 steps in wide mode, 25 in narrow mode; uses imu_ssgb_pkg
`timescale 1ns / 1ps

module imu_ssgb_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  imu_ssgb_pkg::div_req_t            req,
    input  logic [imu_ssgb_pkg::DIV_W-1:0]    num,
    input  logic [imu_ssgb_pkg::DEN_W-1:0]    den,
    output logic                              done,
    output logic [imu_ssgb_pkg::DIV_W-1:0]    quo
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [imu_ssgb_pkg::ITER_W-1:0]   cnt_reg;
    logic [imu_ssgb_pkg::DEN_W-1:0]    rem_reg;
    logic [imu_ssgb_pkg::DIV_W-1:0]    quo_reg;

    logic [imu_ssgb_pkg::DEN_W:0]      shifted;
    logic [imu_ssgb_pkg::DEN_W:0]      diff;
    logic                              ge;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[imu_ssgb_pkg::DIV_W-1]};
        diff    = shifted - {1'b0, den};
        ge      = (shifted >= {1'b0, den});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.wide ? imu_ssgb_pkg::ITER_W'(imu_ssgb_pkg::DIV_W)
                                     : imu_ssgb_pkg::ITER_W'(imu_ssgb_pkg::NARROW_ITERS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == imu_ssgb_pkg::ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.wide ? num
                                : (num << (imu_ssgb_pkg::DIV_W - imu_ssgb_pkg::NARROW_ITERS));
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[imu_ssgb_pkg::DEN_W-1:0] : shifted[imu_ssgb_pkg::DEN_W-1:0];
            quo_reg <= {quo_reg[imu_ssgb_pkg::DIV_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

### hdl/imu_sample_scale_gyro_bias.sv
// imu_sample_scale_gyro_bias: top level, frame scaling and gyro bias calibration
// sequencer around one shared divider; uses imu_ssgb_pkg and imu_ssgb_div
//
//   channel   dir  signals                      content
//   s_axis    in   tdata[111:0], tuser[1:0]     seven raw samples, command
//   m_axis    out  tdata[119:0], tuser[0:0]     scaled frame, calib done flag
//   cfg       in   cfg_we, cfg_wdata[15:0]      calib_samples register
//
// a measure or begin beat runs four 25-step divisions, then the emit and idle states
// a beat that completes a calibration adds three 40-step divisions
// s_axis_tready is high only while the sequencer is idle
// a finished result sits in the output register; the next beat may be taken meanwhile
// emit waits while an earlier result is still held by m_axis_tready low
// rst_n clears bias, sums, count and the register to 100; no clearing pass
`timescale 1ns / 1ps

module imu_sample_scale_gyro_bias
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // accel_x_raw, accel_y_raw, accel_z_raw, temp_raw_in, gyro_x_raw, gyro_y_raw, gyro_z_raw
    input  logic [111:0]  s_axis_tdata,
    // cmd
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // accel_x_q12, accel_y_q12, accel_z_q12, rate_x, rate_y, rate_z, temp_centi_c, zero pad
    output logic [119:0]  m_axis_tdata,
    // calib_done
    output logic [0:0]    m_axis_tuser,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata
);

    imu_ssgb_pkg::state_t state_reg, state_next;
    logic [2:0]           op_reg, op_next;

    logic [15:0]          calib_samples_reg;
    logic signed [31:0]   sum_reg  [3];
    logic signed [23:0]   bias_reg [3];
    logic [15:0]          count_reg;
    logic                 done_flag_reg;
    logic                 neg_reg;

    logic signed [15:0]   accel_reg [3];
    logic signed [15:0]   gyro_reg  [3];
    logic signed [15:0]   temp_raw_reg;
    logic signed [17:0]   rate_reg  [3];
    logic signed [14:0]   temp_reg;

    logic                 m_valid_reg;
    logic [119:0]         m_data_reg;
    logic                 m_user_reg;

    logic                 accept;
    logic [1:0]           cmd;
    logic signed [15:0]   gyro_in [3];
    logic [15:0]          count_inc;
    logic [15:0]          target;
    logic                 complete;

    logic [1:0]           axis;
    logic                 is_bias;
    logic signed [imu_ssgb_pkg::NUM_W-1:0] num_s;
    logic [imu_ssgb_pkg::NUM_W-1:0]        mag;
    logic [imu_ssgb_pkg::DEN_W-1:0]        den;
    logic [imu_ssgb_pkg::DIV_W-1:0]        div_num;
    imu_ssgb_pkg::div_req_t                div_req;
    logic                                  div_done;
    logic [imu_ssgb_pkg::DIV_W-1:0]        div_quo;
    logic [imu_ssgb_pkg::DIV_W-1:0]        res;
    logic                                  out_load;

    imu_ssgb_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .num   (div_num),
        .den   (den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign s_axis_tready = (state_reg == imu_ssgb_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cmd           = s_axis_tuser;
    assign gyro_in[0]    = s_axis_tdata[79:64];
    assign gyro_in[1]    = s_axis_tdata[95:80];
    assign gyro_in[2]    = s_axis_tdata[111:96];

    // calibration count and completion
    always_comb
    begin
        count_inc = (count_reg != 16'hFFFF) ? count_reg + 16'd1 : count_reg;
        target    = (calib_samples_reg == 16'd0) ? 16'd1 : calib_samples_reg;
        complete  = (cmd == imu_ssgb_pkg::CMD_CALIB) && (count_inc >= target);
    end

    // divider operand selection
    always_comb
    begin
        is_bias = (op_reg <= imu_ssgb_pkg::OP_BIAS_Z);
        axis    = is_bias ? op_reg[1:0] : 2'(op_reg - imu_ssgb_pkg::OP_RATE_X);
        if (is_bias)
        begin
            num_s = $signed({sum_reg[axis][31], sum_reg[axis], 8'd0});
            den   = count_reg;
        end
        else if (op_reg == imu_ssgb_pkg::OP_TEMP)
        begin
            num_s = ($signed({{25{temp_raw_reg[15]}}, temp_raw_reg}) <<< 2)
                  + $signed({{25{temp_raw_reg[15]}}, temp_raw_reg});
            den   = imu_ssgb_pkg::TEMP_DEN;
        end
        else
        begin
            num_s = $signed({{17{gyro_reg[axis][15]}}, gyro_reg[axis], 8'd0})
                  - $signed({{17{bias_reg[axis][23]}}, bias_reg[axis]});
            den   = imu_ssgb_pkg::RATE_DEN;
        end
        mag     = num_s[imu_ssgb_pkg::NUM_W-1] ? (~num_s + 1'b1) : num_s;
        // round half away from zero
        div_num = mag[imu_ssgb_pkg::DIV_W-1:0]
                + {{(imu_ssgb_pkg::DIV_W-imu_ssgb_pkg::DEN_W){1'b0}}, (den >> 1)};
        res     = neg_reg ? (~div_quo + 1'b1) : div_quo;
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        div_req.start = 1'b0;
        div_req.wide  = is_bias;
        out_load      = 1'b0;
        case (state_reg)
            imu_ssgb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = imu_ssgb_pkg::ST_DIV_START;
                    op_next    = complete ? imu_ssgb_pkg::OP_BIAS_X : imu_ssgb_pkg::OP_RATE_X;
                end
            end
            imu_ssgb_pkg::ST_DIV_START:
            begin
                div_req.start = 1'b1;
                state_next    = imu_ssgb_pkg::ST_DIV_WAIT;
            end
            imu_ssgb_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (op_reg == imu_ssgb_pkg::OP_TEMP)
                    begin
                        state_next = imu_ssgb_pkg::ST_EMIT;
                    end
                    else
                    begin
                        op_next    = op_reg + 3'd1;
                        state_next = imu_ssgb_pkg::ST_DIV_START;
                    end
                end
            end
            imu_ssgb_pkg::ST_EMIT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = imu_ssgb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = imu_ssgb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= imu_ssgb_pkg::ST_IDLE;
            op_reg    <= imu_ssgb_pkg::OP_RATE_X;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_samples_reg <= imu_ssgb_pkg::CALIB_SAMPLES_RESET;
            count_reg         <= '0;
            done_flag_reg     <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i]  <= '0;
                bias_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                calib_samples_reg <= cfg_wdata;
            end
            if (accept)
            begin
                done_flag_reg <= complete;
                if (cmd == imu_ssgb_pkg::CMD_BEGIN)
                begin
                    count_reg <= '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        sum_reg[i]  <= '0;
                        bias_reg[i] <= '0;
                    end
                end
                else if (cmd == imu_ssgb_pkg::CMD_CALIB)
                begin
                    count_reg <= count_inc;
                    for (int i = 0; i < 3; i++)
                    begin
                        sum_reg[i] <= sum_reg[i] + 32'(gyro_in[i]);
                    end
                end
            end
            else if (state_reg == imu_ssgb_pkg::ST_DIV_WAIT && div_done && is_bias)
            begin
                bias_reg[axis] <= res[23:0];
                if (op_reg == imu_ssgb_pkg::OP_BIAS_Z)
                begin
                    count_reg <= '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        sum_reg[i] <= '0;
                    end
                end
            end
        end
    end

    // frame capture and results, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            accel_reg[0] <= s_axis_tdata[15:0];
            accel_reg[1] <= s_axis_tdata[31:16];
            accel_reg[2] <= s_axis_tdata[47:32];
            temp_raw_reg <= s_axis_tdata[63:48];
            for (int i = 0; i < 3; i++)
            begin
                gyro_reg[i] <= gyro_in[i];
            end
        end
        if (div_req.start)
        begin
            neg_reg <= num_s[imu_ssgb_pkg::NUM_W-1];
        end
        if (state_reg == imu_ssgb_pkg::ST_DIV_WAIT && div_done && !is_bias)
        begin
            if (op_reg == imu_ssgb_pkg::OP_TEMP)
            begin
                temp_reg <= res[14:0] + imu_ssgb_pkg::TEMP_OFFSET;
            end
            else
            begin
                rate_reg[axis] <= res[17:0];
            end
        end
        if (out_load)
        begin
            m_data_reg <= {3'd0, temp_reg, rate_reg[2], rate_reg[1], rate_reg[0],
                           accel_reg[2], accel_reg[1], accel_reg[0]};
            m_user_reg <= done_flag_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_user_reg;

endmodule
